>>> sv/rtsf_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample filter package
// Shared widths, register codes, reset values and the structures that pass
// between the front end, the group queue, the back end and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtsf_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int SUM_W     = 16;
   localparam int PROD_W    = 24;
   localparam int DIV_CNT_W = 5;
   localparam int GRP_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int ORIENT_W  = 3;

   localparam logic [SAMPLE_W-1:0] AGREE_LIMIT = 12'd50;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIENTATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MAX     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MAX     = 3'd6;

   localparam int ORIENT_SWAP  = 0;
   localparam int ORIENT_INV_X = 1;
   localparam int ORIENT_INV_Y = 2;

   localparam logic [GRP_W-1:0] GRP_X0 = 2'd0;
   localparam logic [GRP_W-1:0] GRP_Y0 = 2'd1;
   localparam logic [GRP_W-1:0] GRP_X1 = 2'd2;
   localparam logic [GRP_W-1:0] GRP_Y1 = 2'd3;

   localparam logic [ORIENT_W-1:0] RST_ORIENTATION   = 3'd0;
   localparam logic [SAMPLE_W-1:0] RST_SCREEN_WIDTH  = 12'd240;
   localparam logic [SAMPLE_W-1:0] RST_SCREEN_HEIGHT = 12'd320;
   localparam logic [SAMPLE_W-1:0] RST_X_RAW_MIN     = 12'd200;
   localparam logic [SAMPLE_W-1:0] RST_X_RAW_MAX     = 12'd3900;
   localparam logic [SAMPLE_W-1:0] RST_Y_RAW_MIN     = 12'd200;
   localparam logic [SAMPLE_W-1:0] RST_Y_RAW_MAX     = 12'd3900;

   typedef struct packed {
      logic [ORIENT_W-1:0] orientation;
      logic [SAMPLE_W-1:0] screen_width;
      logic [SAMPLE_W-1:0] screen_height;
      logic [SAMPLE_W-1:0] x_raw_min;
      logic [SAMPLE_W-1:0] x_raw_max;
      logic [SAMPLE_W-1:0] y_raw_min;
      logic [SAMPLE_W-1:0] y_raw_max;
   } rtsf_cfg_type;

   typedef struct packed {
      logic [GRP_W-1:0]    grp;
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] high;
   } rtsf_grp_type;

   typedef struct packed {
      logic                start;
      logic [PROD_W-1:0]   num;
      logic [SAMPLE_W-1:0] den;
   } rtsf_div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quo;
   } rtsf_div_rsp_type;

   typedef struct packed {
      logic                accepted;
      logic [SAMPLE_W-1:0] raw_x_avg;
      logic [SAMPLE_W-1:0] raw_y_avg;
      logic [SAMPLE_W-1:0] screen_x;
      logic [SAMPLE_W-1:0] screen_y;
   } rtsf_res_type;

endpackage

>>> sv/rtsf_ifs.sv
// ----------------------------------------------------------------------------
// Touch sample filter channel interfaces
// Sample input, result output and register write channels, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtsf_req_if;
   import rtsf_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                restart;
   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rtsf_rsp_if;
   import rtsf_pkg::*;
   logic                valid;
   logic                ready;
   logic                accepted;
   logic [SAMPLE_W-1:0] raw_x_avg;
   logic [SAMPLE_W-1:0] raw_y_avg;
   logic [SAMPLE_W-1:0] screen_x;
   logic [SAMPLE_W-1:0] screen_y;
   modport source (output valid, output accepted, output raw_x_avg, output raw_y_avg,
                   output screen_x, output screen_y, input ready);
   modport sink   (input valid, input accepted, input raw_x_avg, input raw_y_avg,
                   input screen_x, input screen_y, output ready);
endinterface

interface rtsf_csr_if;
   import rtsf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SAMPLE_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/rtsf_front.sv
// ----------------------------------------------------------------------------
// Touch sample filter front end
// Takes one sample per transfer, tracks the position in the four-group
// sequence and keeps the running sum, minimum and maximum of the group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtsf_front #(
   parameter int SAMPLES_PER_GROUP = 5,
   parameter int DW                = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   rtsf_req_if.sink              req,
   output logic                  push_valid,
   input  logic                  push_ready,
   output rtsf_pkg::rtsf_grp_type push_entry
);
   import rtsf_pkg::*;

   localparam int PW = $clog2(SAMPLES_PER_GROUP);
   localparam int SW = DW + $clog2(SAMPLES_PER_GROUP);

   logic [PW-1:0]    pos_ff, pos_in, pos_cur;
   logic [GRP_W-1:0] grp_ff, grp_in, grp_cur;
   logic [SW-1:0]    sum_ff, sum_in, sum_next;
   logic [DW-1:0]    low_ff, low_in, low_next;
   logic [DW-1:0]    high_ff, high_in, high_next;
   logic [DW-1:0]    smp;
   logic             accept, first, last;

   assign req.ready = push_ready;

   always_comb begin
      accept    = req.valid && req.ready;
      smp       = req.sample[DW-1:0];
      pos_cur   = req.restart ? '0 : pos_ff;
      grp_cur   = req.restart ? GRP_X0 : grp_ff;
      first     = (pos_cur == '0);
      last      = (pos_cur == PW'(SAMPLES_PER_GROUP - 1));
      sum_next  = first ? SW'(smp) : sum_ff + SW'(smp);
      low_next  = (first || smp < low_ff) ? smp : low_ff;
      high_next = (first || smp > high_ff) ? smp : high_ff;

      pos_in  = pos_ff;
      grp_in  = grp_ff;
      sum_in  = sum_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (accept) begin
         pos_in  = last ? '0 : pos_cur + PW'(1);
         grp_in  = last ? grp_cur + GRP_W'(1) : grp_cur;
         sum_in  = sum_next;
         low_in  = low_next;
         high_in = high_next;
      end

      push_valid      = accept && last;
      push_entry.grp  = grp_cur;
      push_entry.sum  = SUM_W'(sum_next);
      push_entry.low  = SAMPLE_W'(low_next);
      push_entry.high = SAMPLE_W'(high_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         grp_ff <= GRP_X0;
      end else begin
         pos_ff <= pos_in;
         grp_ff <= grp_in;
      end
      sum_ff  <= sum_in;
      low_ff  <= low_in;
      high_ff <= high_in;
   end

endmodule

>>> sv/rtsf_queue.sv
// ----------------------------------------------------------------------------
// Touch sample filter group queue
// Two-entry queue of finished group summaries between the front end and the
// back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtsf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rtsf_pkg::rtsf_grp_type in_entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rtsf_pkg::rtsf_grp_type out_entry
);
   import rtsf_pkg::*;

   rtsf_grp_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   always_comb begin
      in_ready  = (count_ff != 2'd2);
      out_valid = (count_ff != 2'd0);
      out_entry = mem_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

>>> sv/rtsf_div.sv
// ----------------------------------------------------------------------------
// Touch sample filter divider
// Restoring divider, one quotient bit per cycle, used by the screen scaling
// divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtsf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rtsf_pkg::rtsf_div_req_type div_req,
   output rtsf_pkg::rtsf_div_rsp_type div_rsp
);
   import rtsf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    num_ff, num_in;
   logic [SAMPLE_W-1:0]  den_ff, den_in;
   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W:0]    trial, trial_sub;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, num_ff[PROD_W-1]};
      fits      = (trial >= {1'b0, den_ff});
      trial_sub = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(PROD_W);
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
         num_in = {num_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      div_rsp.done = done_ff;
      div_rsp.quo  = num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

endmodule

>>> sv/rtsf_back.sv
// ----------------------------------------------------------------------------
// Touch sample filter back end
// Turns group summaries into trimmed means, checks agreement, scales and
// orients the touch, and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtsf_back #(
   parameter int SAMPLES_PER_GROUP = 5,
   parameter int DW                = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rtsf_pkg::rtsf_cfg_type     cfg,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  rtsf_pkg::rtsf_grp_type     pop_entry,
   output rtsf_pkg::rtsf_div_req_type div_req,
   input  rtsf_pkg::rtsf_div_rsp_type div_rsp,
   rtsf_rsp_if.source                 rsp
);
   import rtsf_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MWAIT  = 3'd1;
   localparam logic [2:0] S_XPREP  = 3'd2;
   localparam logic [2:0] S_XWAIT  = 3'd3;
   localparam logic [2:0] S_YPREP  = 3'd4;
   localparam logic [2:0] S_YWAIT  = 3'd5;
   localparam logic [2:0] S_ORIENT = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   // The trimmed mean uses a reciprocal multiplication, which is exact for
   // sums below 2**SUM_W and divisors up to 16.
   localparam int RECIP_SHIFT = SUM_W + 4;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int MPROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** RECIP_SHIFT) + SAMPLES_PER_GROUP - 3) / (SAMPLES_PER_GROUP - 2));

   function automatic logic [SAMPLE_W-1:0] invert_axis(input logic [SAMPLE_W-1:0] v,
                                                      input logic [SAMPLE_W-1:0] span);
      if (span == '0) begin
         return v;
      end else if (v >= span) begin
         return '0;
      end else begin
         return span - v - SAMPLE_W'(1);
      end
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [GRP_W-1:0]    grp_ff, grp_in;
   logic [DW-1:0]       mean_ff, mean_in;
   logic [DW-1:0]       fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in;
   logic [DW-1:0]       xavg_ff, xavg_in, yavg_ff, yavg_in;
   logic [SAMPLE_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   rtsf_res_type        res_ff, res_in;
   rtsf_res_type        out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic [DW-1:0]       mean, dx, dy;
   logic [DW:0]         xsum, ysum;
   logic [SUM_W-1:0]    trim;
   logic [MPROD_W-1:0]  mean_prod;
   logic                axis_y, scale_zero, scale_max;
   logic [SAMPLE_W-1:0] sv, slo, shi, sspan, span_m1, sdiff;
   logic [SAMPLE_W-1:0] ox, oy;

   always_comb begin
      mean      = mean_ff;
      dx        = (fx_ff > sx_ff) ? fx_ff - sx_ff : sx_ff - fx_ff;
      dy        = (fy_ff > mean) ? fy_ff - mean : mean - fy_ff;
      xsum      = {1'b0, fx_ff} + {1'b0, sx_ff};
      ysum      = {1'b0, fy_ff} + {1'b0, mean};
      trim      = pop_entry.sum - SUM_W'(pop_entry.low) - SUM_W'(pop_entry.high);
      mean_prod = MPROD_W'(trim) * MPROD_W'(RECIP);

      axis_y     = (state_ff == S_YPREP);
      sv         = axis_y ? SAMPLE_W'(yavg_ff) : SAMPLE_W'(xavg_ff);
      slo        = axis_y ? cfg.y_raw_min : cfg.x_raw_min;
      shi        = axis_y ? cfg.y_raw_max : cfg.x_raw_max;
      sspan      = axis_y ? cfg.screen_height : cfg.screen_width;
      span_m1    = sspan - SAMPLE_W'(1);
      sdiff      = sv - slo;
      scale_zero = (sspan == '0) || (slo == shi) || (sv <= slo);
      scale_max  = (sv >= shi);

      ox = cfg.orientation[ORIENT_SWAP] ? ty_ff : tx_ff;
      oy = cfg.orientation[ORIENT_SWAP] ? tx_ff : ty_ff;
      if (cfg.orientation[ORIENT_INV_X]) begin
         ox = invert_axis(ox, cfg.screen_width);
      end
      if (cfg.orientation[ORIENT_INV_Y]) begin
         oy = invert_axis(oy, cfg.screen_height);
      end

      state_in     = state_ff;
      grp_in       = grp_ff;
      mean_in      = mean_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      sx_in        = sx_ff;
      xavg_in      = xavg_ff;
      yavg_in      = yavg_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      pop_ready    = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               grp_in   = pop_entry.grp;
               mean_in  = mean_prod[RECIP_SHIFT +: DW];
               state_in = S_MWAIT;
            end
         end
         S_MWAIT: begin
            unique case (grp_ff)
               GRP_X0: begin
                  fx_in    = mean;
                  state_in = S_IDLE;
               end
               GRP_Y0: begin
                  fy_in    = mean;
                  state_in = S_IDLE;
               end
               GRP_X1: begin
                  sx_in    = mean;
                  state_in = S_IDLE;
               end
               GRP_Y1: begin
                  if (SAMPLE_W'(dx) >= AGREE_LIMIT || SAMPLE_W'(dy) >= AGREE_LIMIT) begin
                     res_in   = '0;
                     state_in = S_EMIT;
                  end else begin
                     xavg_in  = xsum[DW:1];
                     yavg_in  = ysum[DW:1];
                     state_in = S_XPREP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_XPREP, S_YPREP: begin
            if (scale_zero || scale_max) begin
               if (axis_y) begin
                  ty_in = scale_zero ? '0 : span_m1;
               end else begin
                  tx_in = scale_zero ? '0 : span_m1;
               end
               state_in = axis_y ? S_ORIENT : S_YPREP;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = PROD_W'(sdiff) * PROD_W'(span_m1);
               div_req.den   = shi - slo;
               state_in      = axis_y ? S_YWAIT : S_XWAIT;
            end
         end
         S_XWAIT: begin
            if (div_rsp.done) begin
               tx_in    = div_rsp.quo[SAMPLE_W-1:0];
               state_in = S_YPREP;
            end
         end
         S_YWAIT: begin
            if (div_rsp.done) begin
               ty_in    = div_rsp.quo[SAMPLE_W-1:0];
               state_in = S_ORIENT;
            end
         end
         S_ORIENT: begin
            res_in.accepted  = 1'b1;
            res_in.raw_x_avg = SAMPLE_W'(xavg_ff);
            res_in.raw_y_avg = SAMPLE_W'(yavg_ff);
            res_in.screen_x  = ox;
            res_in.screen_y  = oy;
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         sx_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         sx_ff        <= sx_in;
      end
      grp_ff  <= grp_in;
      mean_ff <= mean_in;
      xavg_ff <= xavg_in;
      yavg_ff <= yavg_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.accepted  = out_ff.accepted;
   assign rsp.raw_x_avg = out_ff.raw_x_avg;
   assign rsp.raw_y_avg = out_ff.raw_y_avg;
   assign rsp.screen_x  = out_ff.screen_x;
   assign rsp.screen_y  = out_ff.screen_y;

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.accepted |-> (rsp.raw_x_avg == '0) && (rsp.raw_y_avg == '0) &&
                                     (rsp.screen_x == '0) && (rsp.screen_y == '0))
      else $error("Rejected touch carries nonzero coordinates.");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.accepted && (cfg.orientation == '0) && (cfg.screen_width != '0)
      |-> rsp.screen_x < cfg.screen_width)
      else $error("Scaled x lies outside the screen width.");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !$past(rsp.valid) |-> $past(state_ff) == S_EMIT)
      else $error("Result appeared without passing through the emit step.");

endmodule

>>> sv/resistive_touch_sample_filter.sv
// ----------------------------------------------------------------------------
// Resistive touch sample filter
// Reduces X,Y,X,Y groups of converter samples to trimmed means, rejects
// touches whose axis pairs disagree, and scales and orients accepted touches.
// The front end takes one sample per cycle while the group queue has room.
// A trimmed mean passes through the idle and mean-wait states of the back end,
// and each scaling division runs in the bit-serial divider while the back end
// waits; the back end takes no new group summary until it is idle again.
// Reset clears the sequence and restores the register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resistive_touch_sample_filter #(
   parameter int SAMPLES_PER_GROUP = 5,
   parameter int ADC_BITS          = 12
) (
   input logic        clock,
   input logic        reset,
   rtsf_req_if.sink   req_ch,
   rtsf_rsp_if.source rsp_ch,
   rtsf_csr_if.sink   csr_ch
);
   import rtsf_pkg::*;

   localparam int DW = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;

   rtsf_cfg_type     cfg_ff, cfg_in;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   rtsf_grp_type     push_entry, pop_entry;
   rtsf_div_req_type div_req;
   rtsf_div_rsp_type div_rsp;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ORIENTATION:   cfg_in.orientation   = csr_ch.data[ORIENT_W-1:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_ch.data;
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_ch.data;
            CSR_X_RAW_MIN:     cfg_in.x_raw_min     = csr_ch.data;
            CSR_X_RAW_MAX:     cfg_in.x_raw_max     = csr_ch.data;
            CSR_Y_RAW_MIN:     cfg_in.y_raw_min     = csr_ch.data;
            CSR_Y_RAW_MAX:     cfg_in.y_raw_max     = csr_ch.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation   <= RST_ORIENTATION;
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.x_raw_min     <= RST_X_RAW_MIN;
         cfg_ff.x_raw_max     <= RST_X_RAW_MAX;
         cfg_ff.y_raw_min     <= RST_Y_RAW_MIN;
         cfg_ff.y_raw_max     <= RST_Y_RAW_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rtsf_front #(
      .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
      .DW               (DW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry)
   );

   rtsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_entry (push_entry),
      .out_valid(pop_valid),
      .out_ready(pop_ready),
      .out_entry(pop_entry)
   );

   rtsf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   rtsf_back #(
      .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
      .DW               (DW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_entry(pop_entry),
      .div_req  (div_req),
      .div_rsp  (div_rsp),
      .rsp      (rsp_ch)
   );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Touch sample filter testbench
// Streams X,Y,X,Y sample groups into the filter and checks every touch
// result against a cycle-free predictor. The stream mixes complete touches,
// touches cut short by restart and loose noise. It runs through several
// register settings, including the extremes, with random stalls on both
// channels outside the steady-flow phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rtsf_pkg::*;

   localparam int GROUP_LEN     = 5;
   localparam int TOUCH_LEN     = 4 * GROUP_LEN;
   localparam int ADC_MAX       = 4095;
   localparam int MAX_IDLE      = 14;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 200;
   localparam int SETTLE_CYCLES = 400;
   localparam int STALL_LIMIT   = 5000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
   } reading_type;

   logic clock;
   logic reset;

   rtsf_req_if req_ch ();
   rtsf_rsp_if rsp_ch ();
   rtsf_csr_if csr_ch ();

   resistive_touch_sample_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   reading_type  reading_queue[$];
   rtsf_res_type touch_queue[$];

   rtsf_cfg_type        cfg;
   int                  seq_pos;
   int                  grp_sum;
   logic [SAMPLE_W-1:0] grp_low;
   logic [SAMPLE_W-1:0] grp_high;
   logic [SAMPLE_W-1:0] x0_mean;
   logic [SAMPLE_W-1:0] y0_mean;
   logic [SAMPLE_W-1:0] x1_mean;

   int   error_count;
   int   queued_count;
   int   gen_pos;
   int   idle_cycles;
   int   send_wait;
   int   recv_wait;
   logic rsp_armed;
   logic steady_flow;

   always #10 clock = ~clock;

   function automatic logic [SAMPLE_W-1:0] map_to_pixels(int v, int lo, int hi, int span);
      if (span == 0 || lo == hi) return '0;
      if (v <= lo) return '0;
      if (v >= hi) return SAMPLE_W'(span - 1);
      return SAMPLE_W'(((v - lo) * (span - 1)) / (hi - lo));
   endfunction

   function automatic logic [SAMPLE_W-1:0] mirror_pixel(int v, int span);
      if (span == 0) return SAMPLE_W'(v);
      return (v >= span) ? '0 : SAMPLE_W'(span - 1 - v);
   endfunction

   function automatic void clear_group();
      grp_sum  = 0;
      grp_low  = '1;
      grp_high = '0;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
      case (idx)
         CSR_ORIENTATION:   cfg.orientation   = val[ORIENT_W-1:0];
         CSR_SCREEN_WIDTH:  cfg.screen_width  = val;
         CSR_SCREEN_HEIGHT: cfg.screen_height = val;
         CSR_X_RAW_MIN:     cfg.x_raw_min     = val;
         CSR_X_RAW_MAX:     cfg.x_raw_max     = val;
         CSR_Y_RAW_MIN:     cfg.y_raw_min     = val;
         CSR_Y_RAW_MAX:     cfg.y_raw_max     = val;
         default: ;
      endcase
   endfunction

   function automatic void absorb_sample(logic [SAMPLE_W-1:0] s, logic restart);
      int               pos;
      int               mean;
      int               dx;
      int               dy;
      int               x_avg;
      int               y_avg;
      logic [SAMPLE_W-1:0] tx;
      logic [SAMPLE_W-1:0] ty;
      logic [SAMPLE_W-1:0] tmp;
      logic [GRP_W-1:0] grp_code;
      rtsf_res_type     res;
      if (restart) begin
         seq_pos = 0;
         clear_group();
      end
      if (seq_pos >= TOUCH_LEN) seq_pos = 0;
      grp_sum += int'(s);
      if (s < grp_low) grp_low = s;
      if (s > grp_high) grp_high = s;
      pos      = seq_pos % GROUP_LEN;
      grp_code = GRP_W'(seq_pos / GROUP_LEN);
      seq_pos++;
      if (pos != GROUP_LEN - 1) return;
      mean = (grp_sum - int'(grp_low) - int'(grp_high)) / (GROUP_LEN - 2);
      clear_group();
      case (grp_code)
         GRP_X0: begin
            x0_mean = SAMPLE_W'(mean);
            return;
         end
         GRP_Y0: begin
            y0_mean = SAMPLE_W'(mean);
            return;
         end
         GRP_X1: begin
            x1_mean = SAMPLE_W'(mean);
            return;
         end
         default: ;
      endcase
      seq_pos = 0;
      res = '0;
      dx  = int'(x0_mean) - int'(x1_mean);
      dy  = int'(y0_mean) - mean;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx < int'(AGREE_LIMIT) && dy < int'(AGREE_LIMIT)) begin
         x_avg = (int'(x0_mean) + int'(x1_mean)) / 2;
         y_avg = (int'(y0_mean) + mean) / 2;
         tx = map_to_pixels(x_avg, int'(cfg.x_raw_min), int'(cfg.x_raw_max),
                            int'(cfg.screen_width));
         ty = map_to_pixels(y_avg, int'(cfg.y_raw_min), int'(cfg.y_raw_max),
                            int'(cfg.screen_height));
         if (cfg.orientation[ORIENT_SWAP]) begin
            tmp = tx;
            tx  = ty;
            ty  = tmp;
         end
         if (cfg.orientation[ORIENT_INV_X]) tx = mirror_pixel(int'(tx), int'(cfg.screen_width));
         if (cfg.orientation[ORIENT_INV_Y]) ty = mirror_pixel(int'(ty), int'(cfg.screen_height));
         res.accepted  = 1'b1;
         res.raw_x_avg = SAMPLE_W'(x_avg);
         res.raw_y_avg = SAMPLE_W'(y_avg);
         res.screen_x  = tx;
         res.screen_y  = ty;
      end
      touch_queue.push_back(res);
   endfunction

   function automatic void compare_touch(rtsf_res_type got);
      rtsf_res_type want;
      if (touch_queue.size() == 0) begin
         $error("touch result with no expectation pending");
         error_count++;
         return;
      end
      want = touch_queue.pop_front();
      if (got.accepted !== want.accepted) begin
         $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
         error_count++;
      end
      if (got.raw_x_avg !== want.raw_x_avg) begin
         $error("raw_x_avg: expected %0d, got %0d", want.raw_x_avg, got.raw_x_avg);
         error_count++;
      end
      if (got.raw_y_avg !== want.raw_y_avg) begin
         $error("raw_y_avg: expected %0d, got %0d", want.raw_y_avg, got.raw_y_avg);
         error_count++;
      end
      if (got.screen_x !== want.screen_x) begin
         $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
         error_count++;
      end
      if (got.screen_y !== want.screen_y) begin
         $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : feeder
      int          wait_n;
      reading_type r;
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.sample  <= '0;
         req_ch.restart <= 1'b0;
         send_wait      <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) absorb_sample(req_ch.sample, req_ch.restart);
         if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) wait_n = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
            else wait_n = send_wait;
            if (wait_n == 0 && reading_queue.size() != 0) begin
               r = reading_queue.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.sample  <= r.sample;
               req_ch.restart <= r.restart;
               send_wait      <= 0;
            end else begin
               req_ch.valid <= 1'b0;
               send_wait    <= (wait_n > 0) ? wait_n - 1 : 0;
            end
         end
      end
   end

   always @(posedge clock) begin : collector
      int           w;
      rtsf_res_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_armed    <= 1'b0;
         recv_wait    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.accepted  = rsp_ch.accepted;
            got.raw_x_avg = rsp_ch.raw_x_avg;
            got.raw_y_avg = rsp_ch.raw_y_avg;
            got.screen_x  = rsp_ch.screen_x;
            got.screen_y  = rsp_ch.screen_y;
            compare_touch(got);
         end
         if (steady_flow) begin
            rsp_ch.ready <= 1'b1;
            rsp_armed    <= 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_ch.ready <= 1'b0;
            rsp_armed    <= 1'b0;
         end else if (rsp_ch.valid && !rsp_armed) begin
            w = $urandom_range(0, MAX_IDLE);
            rsp_ch.ready <= (w == 0);
            recv_wait    <= (w == 0) ? 0 : w - 1;
            rsp_armed    <= 1'b1;
         end else if (rsp_armed && !rsp_ch.ready) begin
            if (recv_wait == 0) rsp_ch.ready <= 1'b1;
            else recv_wait <= recv_wait - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int clip_adc(int v);
      return (v < 0) ? 0 : ((v > ADC_MAX) ? ADC_MAX : v);
   endfunction

   function automatic int random_center();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 300);
         1:       return $urandom_range(ADC_MAX - 300, ADC_MAX);
         default: return $urandom_range(0, ADC_MAX);
      endcase
   endfunction

   task automatic push_reading(int s, bit restart);
      reading_type r;
      r.sample  = SAMPLE_W'(s);
      r.restart = restart;
      reading_queue.push_back(r);
      if (restart) gen_pos = 0;
      gen_pos = (gen_pos + 1) % TOUCH_LEN;
      queued_count++;
   endtask

   task automatic push_group(int center, int spread, bit restart_first);
      int s;
      for (int i = 0; i < GROUP_LEN; i++) begin
         s = clip_adc(center + int'($urandom_range(0, 2 * spread)) - spread);
         if ($urandom_range(0, 9) == 0) s = $urandom_range(0, ADC_MAX);
         push_reading(s, restart_first && i == 0);
      end
   endtask

   task automatic push_touch();
      int xc;
      int yc;
      int dx;
      int dy;
      int spread;
      bit restart;
      restart = (gen_pos != 0) || ($urandom_range(0, 1) == 1);
      xc      = random_center();
      yc      = random_center();
      dx      = int'($urandom_range(0, 160)) - 80;
      dy      = int'($urandom_range(0, 160)) - 80;
      spread  = ($urandom_range(0, 7) == 0) ? ADC_MAX : $urandom_range(0, 30);
      push_group(xc, spread, restart);
      push_group(yc, spread, 1'b0);
      push_group(xc + dx, spread, 1'b0);
      push_group(yc + dy, spread, 1'b0);
   endtask

   task automatic push_broken();
      int n;
      n = $urandom_range(1, TOUCH_LEN - 1);
      for (int i = 0; i < n; i++) push_reading($urandom_range(0, ADC_MAX), i == 0);
   endtask

   task automatic push_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
         push_reading($urandom_range(0, ADC_MAX), $urandom_range(0, 9) == 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      apply_register(idx, val);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_window(logic [CSR_IDX_W-1:0] lo_idx, logic [CSR_IDX_W-1:0] hi_idx);
      int lo;
      int hi;
      if ($urandom_range(0, 3) == 0) begin
         lo = $urandom_range(0, ADC_MAX);
         hi = $urandom_range(0, ADC_MAX);
      end else begin
         lo = $urandom_range(0, 1500);
         hi = $urandom_range(2500, ADC_MAX);
      end
      write_reg(lo_idx, SAMPLE_W'(lo));
      write_reg(hi_idx, SAMPLE_W'(hi));
   endtask

   task automatic load_settings(int ph);
      case (ph)
         1: begin
            write_reg(CSR_ORIENTATION, 12'hFFF);
            write_reg(CSR_SCREEN_WIDTH, 12'd4095);
            write_reg(CSR_SCREEN_HEIGHT, 12'd4095);
            write_reg(CSR_X_RAW_MIN, 12'd0);
            write_reg(CSR_X_RAW_MAX, 12'd4095);
            write_reg(CSR_Y_RAW_MIN, 12'd0);
            write_reg(CSR_Y_RAW_MAX, 12'd4095);
            write_reg(CSR_UNUSED, 12'hFFF);
         end
         2: begin
            write_reg(CSR_SCREEN_WIDTH, 12'd0);
            write_reg(CSR_SCREEN_HEIGHT, 12'd0);
            write_reg(CSR_ORIENTATION, 12'd6);
         end
         3: begin
            write_reg(CSR_ORIENTATION, 12'd7);
            write_reg(CSR_SCREEN_WIDTH, 12'd1);
            write_reg(CSR_SCREEN_HEIGHT, 12'd2);
            write_reg(CSR_X_RAW_MIN, 12'd2000);
            write_reg(CSR_X_RAW_MAX, 12'd2000);
            write_reg(CSR_Y_RAW_MIN, 12'd3000);
            write_reg(CSR_Y_RAW_MAX, 12'd1000);
         end
         default: begin
            write_reg(CSR_ORIENTATION, SAMPLE_W'($urandom));
            write_reg(CSR_SCREEN_WIDTH,
                      ($urandom_range(0, 7) == 0) ? 12'd0 : SAMPLE_W'($urandom_range(1, ADC_MAX)));
            write_reg(CSR_SCREEN_HEIGHT,
                      ($urandom_range(0, 7) == 0) ? 12'd0 : SAMPLE_W'($urandom_range(1, ADC_MAX)));
            write_window(CSR_X_RAW_MIN, CSR_X_RAW_MAX);
            write_window(CSR_Y_RAW_MIN, CSR_Y_RAW_MAX);
            write_reg(CSR_UNUSED, SAMPLE_W'($urandom));
         end
      endcase
   endtask

   task automatic wait_drained();
      while (reading_queue.size() != 0 || req_ch.valid || touch_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase_end;
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.restart = 1'b0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      steady_flow    = 1'b0;
      error_count    = 0;
      queued_count   = 0;
      gen_pos        = 0;
      cfg.orientation   = RST_ORIENTATION;
      cfg.screen_width  = RST_SCREEN_WIDTH;
      cfg.screen_height = RST_SCREEN_HEIGHT;
      cfg.x_raw_min     = RST_X_RAW_MIN;
      cfg.x_raw_max     = RST_X_RAW_MAX;
      cfg.y_raw_min     = RST_Y_RAW_MIN;
      cfg.y_raw_max     = RST_Y_RAW_MAX;
      seq_pos = 0;
      x0_mean = '0;
      y0_mean = '0;
      x1_mean = '0;
      clear_group();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A clean touch whose groups carry both converter extremes as the
      // trimmed outliers, then a measurement abandoned after three samples.
      push_reading(4095, 1'b1);
      push_reading(1000, 1'b0);
      push_reading(1010, 1'b0);
      push_reading(1020, 1'b0);
      push_reading(0, 1'b0);
      push_reading(500, 1'b0);
      push_reading(0, 1'b0);
      push_reading(510, 1'b0);
      push_reading(4095, 1'b0);
      push_reading(520, 1'b0);
      push_reading(1005, 1'b0);
      push_reading(4095, 1'b0);
      push_reading(1015, 1'b0);
      push_reading(0, 1'b0);
      push_reading(1025, 1'b0);
      push_reading(505, 1'b0);
      push_reading(515, 1'b0);
      push_reading(525, 1'b0);
      push_reading(0, 1'b0);
      push_reading(4095, 1'b0);
      push_reading(4095, 1'b1);
      push_reading(4095, 1'b0);
      push_reading(4095, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            load_settings(ph);
         end
         @(posedge clock);
         steady_flow <= (ph % 3 == 2);
         phase_end = queued_count + PHASE_ITEMS;
         while (queued_count < phase_end) begin
            case ($urandom_range(0, 15))
               11, 12, 13: push_broken();
               14, 15:     push_noise();
               default:    push_touch();
            endcase
         end
      end

      wait_drained();
      if (error_count == 0 && touch_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/rtsf_pkg.sv
sv/rtsf_ifs.sv
sv/rtsf_front.sv
sv/rtsf_queue.sv
sv/rtsf_div.sv
sv/rtsf_back.sv
sv/resistive_touch_sample_filter.sv
bench/tb.sv
